// File: src/bra_pkg.sv
// Shared types and constants of the bitmap run allocator.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package bra_pkg;

    // Field widths of the request and result words.
    localparam int TOK_W = 13;
    localparam int SZ_W  = 25;
    localparam int ST_W  = 2;
    localparam int FN_W  = 2;

    // Default sizing of the unit map.
    localparam int MAX_UNITS_DEF  = 4096;
    localparam int UNIT_BYTES_DEF = 4096;

    // Function codes.
    localparam logic [FN_W-1:0] FUNC_ALLOC = 2'd0;
    localparam logic [FN_W-1:0] FUNC_FREE  = 2'd1;
    localparam logic [FN_W-1:0] FUNC_CHECK = 2'd2;

    // Result status codes.
    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_INVALID = 2'd1;
    localparam logic [ST_W-1:0] ST_NOSPACE = 2'd2;

    // Configuration register indexes and reset values.
    localparam int                CFG_IDX_W       = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_UNITS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STORE_BYTES = 1'b1;
    localparam logic [TOK_W-1:0]  TOTAL_UNITS_RST = 13'd4096;
    localparam logic [SZ_W-1:0]   STORE_BYTES_RST = 25'd16777216;

    typedef struct packed {
        logic [FN_W-1:0]  func;
        logic [TOK_W-1:0] token;
        logic [SZ_W-1:0]  size_bytes;
    } bra_req_t;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [TOK_W-1:0] new_token;
        logic [TOK_W-1:0] used_count;
    } bra_rsp_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_CHK,
        S_SCAN,
        S_MARK,
        S_HINT,
        S_VER,
        S_UNMARK,
        S_FIN
    } bra_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_WIPE,
        OP_DIV,
        OP_SCAN_INIT,
        OP_SCAN,
        OP_MARK,
        OP_HINT,
        OP_VER_INIT,
        OP_VER,
        OP_UNMARK,
        OP_DONE
    } bra_op_t;

    // Command from the controller to the datapath.
    typedef struct packed {
        bra_op_t         op;
        logic [ST_W-1:0] res;
    } bra_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic wipe_last;
        logic req_bad;
        logic no_room;
        logic is_alloc;
        logic is_free;
        logic scan_found;
        logic scan_miss;
        logic mark_last;
        logic hint_stop;
        logic ver_fail;
        logic ver_last;
    } bra_sts_t;

endpackage

`default_nettype wire

// File: src/bitmap_run_allocator.sv
// Top level of the bitmap run allocator: controller plus datapath.
// Depends on bra_pkg, bra_ctrl and bra_dp.
//
// A word is taken when start is high and busy is low; its single result word
// appears on rsp for one cycle with done high, and must be taken then. After
// reset the map is cleared one unit per cycle with busy high. Each word then
// passes a load step, a step in which a reciprocal multiplication turns bytes
// into units, and a check step. Allocate adds a map scan of one unit per cycle
// from the hint up to the end of the fitting run, the marking of each unit of
// the run, and a hint scan over the used units from the hint on. Free and check
// read one unit per cycle over the run; free then clears one unit per cycle and
// finishes in a final state. The result word is registered in the cycle after
// the last step.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_run_allocator #(
    parameter int MAX_UNITS  = bra_pkg::MAX_UNITS_DEF,
    parameter int UNIT_BYTES = bra_pkg::UNIT_BYTES_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  bra_pkg::bra_req_t                    req,
    output logic                                 done,
    output bra_pkg::bra_rsp_t                    rsp,
    input  wire logic                            cfg_we,
    input  wire logic [bra_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  wire logic [bra_pkg::SZ_W-1:0]        cfg_data
);

    bra_pkg::bra_cmd_t cmd;
    bra_pkg::bra_sts_t sts;

    // Sequencer.
    bra_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Map, counters and result register.
    bra_dp #(
        .MAX_UNITS  (MAX_UNITS),
        .UNIT_BYTES (UNIT_BYTES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .sts      (sts),
        .done     (done),
        .rsp      (rsp)
    );

endmodule

`default_nettype wire

// File: src/bra_ctrl.sv
// Controller of the bitmap run allocator: sequences clearing, division,
// search, marking, hint scan, verification and unmarking. Uses bra_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bra_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  bra_pkg::bra_sts_t  sts,
    output bra_pkg::bra_cmd_t  cmd,
    output logic               busy
);

    bra_pkg::bra_state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bra_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bra_pkg::S_CLEAR:
            begin
                if (sts.wipe_last) state_next = bra_pkg::S_IDLE;
            end
            bra_pkg::S_IDLE:
            begin
                if (start) state_next = bra_pkg::S_DIV;
            end
            bra_pkg::S_DIV:
            begin
                state_next = bra_pkg::S_CHK;
            end
            bra_pkg::S_CHK:
            begin
                priority if (sts.req_bad)                  state_next = bra_pkg::S_IDLE;
                else if (sts.is_alloc && sts.no_room)     state_next = bra_pkg::S_IDLE;
                else if (sts.is_alloc)                    state_next = bra_pkg::S_SCAN;
                else                                      state_next = bra_pkg::S_VER;
            end
            bra_pkg::S_SCAN:
            begin
                priority if (sts.scan_found) state_next = bra_pkg::S_MARK;
                else if (sts.scan_miss)      state_next = bra_pkg::S_IDLE;
            end
            bra_pkg::S_MARK:
            begin
                if (sts.mark_last) state_next = bra_pkg::S_HINT;
            end
            bra_pkg::S_HINT:
            begin
                if (sts.hint_stop) state_next = bra_pkg::S_IDLE;
            end
            bra_pkg::S_VER:
            begin
                priority if (sts.ver_fail)         state_next = bra_pkg::S_IDLE;
                else if (sts.ver_last && sts.is_free) state_next = bra_pkg::S_UNMARK;
                else if (sts.ver_last)             state_next = bra_pkg::S_IDLE;
            end
            bra_pkg::S_UNMARK:
            begin
                if (sts.mark_last) state_next = bra_pkg::S_FIN;
            end
            bra_pkg::S_FIN:
            begin
                state_next = bra_pkg::S_IDLE;
            end
            default:
            begin
                state_next = bra_pkg::S_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd.op  = bra_pkg::OP_NONE;
        cmd.res = bra_pkg::ST_OK;
        unique case (state_reg)
            bra_pkg::S_CLEAR:
            begin
                cmd.op = bra_pkg::OP_WIPE;
            end
            bra_pkg::S_IDLE:
            begin
                if (start) cmd.op = bra_pkg::OP_LOAD;
            end
            bra_pkg::S_DIV:
            begin
                cmd.op = bra_pkg::OP_DIV;
            end
            bra_pkg::S_CHK:
            begin
                priority if (sts.req_bad)
                begin
                    cmd.op  = bra_pkg::OP_DONE;
                    cmd.res = bra_pkg::ST_INVALID;
                end
                else if (sts.is_alloc && sts.no_room)
                begin
                    cmd.op  = bra_pkg::OP_DONE;
                    cmd.res = bra_pkg::ST_NOSPACE;
                end
                else if (sts.is_alloc)
                begin
                    cmd.op = bra_pkg::OP_SCAN_INIT;
                end
                else
                begin
                    cmd.op = bra_pkg::OP_VER_INIT;
                end
            end
            bra_pkg::S_SCAN:
            begin
                priority if (sts.scan_found)
                begin
                    cmd.op = bra_pkg::OP_SCAN;
                end
                else if (sts.scan_miss)
                begin
                    cmd.op  = bra_pkg::OP_DONE;
                    cmd.res = bra_pkg::ST_NOSPACE;
                end
                else
                begin
                    cmd.op = bra_pkg::OP_SCAN;
                end
            end
            bra_pkg::S_MARK:
            begin
                cmd.op = bra_pkg::OP_MARK;
            end
            bra_pkg::S_HINT:
            begin
                cmd.op = sts.hint_stop ? bra_pkg::OP_DONE : bra_pkg::OP_HINT;
            end
            bra_pkg::S_VER:
            begin
                priority if (sts.ver_fail)
                begin
                    cmd.op  = bra_pkg::OP_DONE;
                    cmd.res = bra_pkg::ST_INVALID;
                end
                else if (sts.ver_last && !sts.is_free)
                begin
                    cmd.op = bra_pkg::OP_DONE;
                end
                else
                begin
                    cmd.op = bra_pkg::OP_VER;
                end
            end
            bra_pkg::S_UNMARK:
            begin
                cmd.op = bra_pkg::OP_UNMARK;
            end
            bra_pkg::S_FIN:
            begin
                cmd.op = bra_pkg::OP_DONE;
            end
            default:
            begin
                cmd.op = bra_pkg::OP_NONE;
            end
        endcase
    end

    assign busy = (state_reg != bra_pkg::S_IDLE);

endmodule

`default_nettype wire

// File: src/bra_dp.sv
// Datapath of the bitmap run allocator: occupancy memory, unit-count
// multiplier, scan pointers, counters and result register. Depends on bra_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bra_dp #(
    parameter int MAX_UNITS  = bra_pkg::MAX_UNITS_DEF,
    parameter int UNIT_BYTES = bra_pkg::UNIT_BYTES_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  bra_pkg::bra_req_t                    req,
    input  wire logic                            cfg_we,
    input  wire logic [bra_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  wire logic [bra_pkg::SZ_W-1:0]        cfg_data,
    input  bra_pkg::bra_cmd_t                    cmd,
    output bra_pkg::bra_sts_t                    sts,
    output logic                                 done,
    output bra_pkg::bra_rsp_t                    rsp
);

    localparam int AW  = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
    localparam int CW  = ($clog2(MAX_UNITS + 1) > bra_pkg::TOK_W) ?
                         $clog2(MAX_UNITS + 1) : bra_pkg::TOK_W;
    localparam int SZ  = bra_pkg::SZ_W;
    localparam int XW  = ((CW > SZ) ? CW : SZ) + 1;
    // Rounded-up division by the unit size through a reciprocal product.
    localparam int NW  = SZ + 1;
    localparam int LB  = $clog2(UNIT_BYTES);
    localparam int MW  = NW + 1;
    localparam int PW  = NW + MW;
    localparam logic [63:0] RECIP64 = ((64'd1 << (NW + LB)) + 64'(UNIT_BYTES) - 64'd1) /
                                      64'(UNIT_BYTES);
    localparam logic [MW-1:0] RECIP = RECIP64[MW-1:0];

    // Occupancy memory, one bit per unit.
    logic mem [MAX_UNITS];

    logic [bra_pkg::FN_W-1:0]  func_reg;
    logic [bra_pkg::TOK_W-1:0] tok_reg;
    logic [SZ-1:0]             size_reg;
    logic [bra_pkg::TOK_W-1:0] total_reg;
    logic [SZ-1:0]             store_reg;
    logic [CW-1:0]             units_reg;
    logic [XW-1:0]             cnt_reg;
    logic [CW-1:0]             hint_reg;
    logic [CW-1:0]             used_reg;
    logic [CW-1:0]             ptr_reg;
    logic                      pvld_reg;
    logic [CW-1:0]             pidx_reg;
    logic                      rd_reg;
    logic [XW-1:0]             run_reg;
    logic [CW-1:0]             first_reg;
    logic [AW-1:0]             wptr_reg;
    logic [XW-1:0]             wleft_reg;
    logic [XW-1:0]             ileft_reg;
    logic [XW-1:0]             vleft_reg;
    logic                      done_reg;
    bra_pkg::bra_rsp_t         rsp_reg;

    logic [CW-1:0] live_units;
    logic [NW-1:0] num_w;
    logic [PW-1:0] prod_w;
    logic [XW-1:0] cnt_w;
    logic [XW-1:0] first_x;
    logic [XW-1:0] found_first;
    logic          tok_zero;
    logic          size_zero;
    logic          size_big;
    logic          range_bad;
    logic          req_bad;
    logic          scan_issue;
    logic          found;
    logic          mem_we;
    logic          mem_wd;

    // Effective unit count and the unit count of the request size.
    assign live_units = (CW'(total_reg) < CW'(MAX_UNITS)) ? CW'(total_reg) : CW'(MAX_UNITS);
    assign num_w      = NW'(size_reg) + NW'(UNIT_BYTES - 1);
    assign prod_w     = {{MW{1'b0}}, num_w} * {{NW{1'b0}}, RECIP};
    assign cnt_w      = cnt_reg;

    // Request checks on the loaded word.
    assign first_x   = XW'(tok_reg) - XW'(1);
    assign tok_zero  = (tok_reg == '0);
    assign size_zero = (size_reg == '0);
    assign size_big  = (size_reg > store_reg);
    assign range_bad = tok_zero || size_zero || (first_x >= XW'(units_reg)) ||
                       (cnt_w > (XW'(units_reg) - first_x));

    always_comb
    begin
        unique case (func_reg)
            bra_pkg::FUNC_ALLOC: req_bad = size_zero || size_big;
            bra_pkg::FUNC_FREE:  req_bad = range_bad;
            bra_pkg::FUNC_CHECK: req_bad = range_bad || size_big;
            default:             req_bad = 1'b1;
        endcase
    end

    // Scan state of the pipelined map read.
    assign scan_issue  = (ptr_reg < units_reg);
    assign found       = pvld_reg && !rd_reg && ((run_reg + XW'(1)) == cnt_w);
    assign found_first = XW'(pidx_reg) + XW'(1) - cnt_w;

    assign sts.wipe_last  = (wptr_reg == AW'(MAX_UNITS - 1));
    assign sts.req_bad    = req_bad;
    assign sts.no_room    = (hint_reg >= units_reg);
    assign sts.is_alloc   = (func_reg == bra_pkg::FUNC_ALLOC);
    assign sts.is_free    = (func_reg == bra_pkg::FUNC_FREE);
    assign sts.scan_found = found;
    assign sts.scan_miss  = !pvld_reg && !scan_issue;
    assign sts.mark_last  = (wleft_reg == XW'(1));
    assign sts.hint_stop  = pvld_reg ? !rd_reg : !scan_issue;
    assign sts.ver_fail   = pvld_reg && !rd_reg;
    assign sts.ver_last   = pvld_reg && rd_reg && (vleft_reg == XW'(1));

    // Memory write port.
    assign mem_we = (cmd.op == bra_pkg::OP_WIPE) || (cmd.op == bra_pkg::OP_MARK) ||
                    (cmd.op == bra_pkg::OP_UNMARK);
    assign mem_wd = (cmd.op == bra_pkg::OP_MARK);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wptr_reg] <= mem_wd;
        end
        rd_reg <= mem[ptr_reg[AW-1:0]];
    end

    // Request and unit-count registers, which need no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.op == bra_pkg::OP_LOAD)
        begin
            func_reg  <= req.func;
            tok_reg   <= req.token;
            size_reg  <= req.size_bytes;
            units_reg <= live_units;
        end
        else if (cmd.op == bra_pkg::OP_DIV)
        begin
            cnt_reg <= XW'(prod_w >> (NW + LB));
        end
    end

    // Control state, counters and pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= bra_pkg::TOTAL_UNITS_RST;
            store_reg <= bra_pkg::STORE_BYTES_RST;
            hint_reg  <= '0;
            used_reg  <= '0;
            wptr_reg  <= '0;
            ptr_reg   <= '0;
            pvld_reg  <= 1'b0;
            pidx_reg  <= '0;
            run_reg   <= '0;
            first_reg <= '0;
            wleft_reg <= '0;
            ileft_reg <= '0;
            vleft_reg <= '0;
            done_reg  <= 1'b0;
            rsp_reg   <= '0;
        end
        else
        begin
            done_reg <= (cmd.op == bra_pkg::OP_DONE);
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    bra_pkg::CFG_TOTAL_UNITS: total_reg <= cfg_data[bra_pkg::TOK_W-1:0];
                    bra_pkg::CFG_STORE_BYTES: store_reg <= cfg_data;
                    default: ;
                endcase
            end
            unique case (cmd.op)
                bra_pkg::OP_WIPE:
                begin
                    wptr_reg <= wptr_reg + AW'(1);
                end
                bra_pkg::OP_SCAN_INIT:
                begin
                    ptr_reg  <= hint_reg;
                    pvld_reg <= 1'b0;
                    run_reg  <= '0;
                end
                bra_pkg::OP_SCAN:
                begin
                    if (scan_issue) ptr_reg <= ptr_reg + CW'(1);
                    pvld_reg <= scan_issue;
                    pidx_reg <= ptr_reg;
                    if (pvld_reg) run_reg <= rd_reg ? '0 : run_reg + XW'(1);
                    if (found)
                    begin
                        first_reg <= found_first[CW-1:0];
                        wptr_reg  <= found_first[AW-1:0];
                        wleft_reg <= cnt_w;
                    end
                end
                bra_pkg::OP_MARK:
                begin
                    wptr_reg  <= wptr_reg + AW'(1);
                    wleft_reg <= wleft_reg - XW'(1);
                    if (wleft_reg == XW'(1))
                    begin
                        used_reg <= used_reg + cnt_w[CW-1:0];
                        ptr_reg  <= hint_reg;
                        pvld_reg <= 1'b0;
                    end
                end
                bra_pkg::OP_HINT:
                begin
                    if (scan_issue) ptr_reg <= ptr_reg + CW'(1);
                    pvld_reg <= scan_issue;
                    pidx_reg <= ptr_reg;
                    if (pvld_reg && rd_reg) hint_reg <= pidx_reg + CW'(1);
                end
                bra_pkg::OP_VER_INIT:
                begin
                    first_reg <= first_x[CW-1:0];
                    ptr_reg   <= first_x[CW-1:0];
                    wptr_reg  <= first_x[AW-1:0];
                    ileft_reg <= cnt_w;
                    vleft_reg <= cnt_w;
                    wleft_reg <= cnt_w;
                    pvld_reg  <= 1'b0;
                end
                bra_pkg::OP_VER:
                begin
                    if (ileft_reg != '0)
                    begin
                        ptr_reg   <= ptr_reg + CW'(1);
                        ileft_reg <= ileft_reg - XW'(1);
                    end
                    pvld_reg <= (ileft_reg != '0);
                    if (pvld_reg) vleft_reg <= vleft_reg - XW'(1);
                end
                bra_pkg::OP_UNMARK:
                begin
                    wptr_reg  <= wptr_reg + AW'(1);
                    wleft_reg <= wleft_reg - XW'(1);
                    if (wleft_reg == XW'(1))
                    begin
                        used_reg <= used_reg - cnt_w[CW-1:0];
                        if (first_reg < hint_reg) hint_reg <= first_reg;
                    end
                end
                bra_pkg::OP_DONE:
                begin
                    rsp_reg.status     <= cmd.res;
                    rsp_reg.new_token  <= (sts.is_alloc && (cmd.res == bra_pkg::ST_OK)) ?
                                          bra_pkg::TOK_W'(first_reg + CW'(1)) : '0;
                    rsp_reg.used_count <= used_reg[bra_pkg::TOK_W-1:0];
                end
                default: ;
            endcase
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

`default_nettype wire

// File: src/bra_checker.sv
// Port-level checks of the bitmap run allocator, bound to the top level.
// Depends on bra_pkg and bitmap_run_allocator.
`timescale 1ns / 1ps
`default_nettype none

module bra_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input bra_pkg::bra_rsp_t rsp
);

    // A taken word keeps the block busy in the next cycle.
    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("word taken but block not busy");

    // A result appears only when the block is ready again.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // One result per word: the strobe never stays high.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held");

    // A failed request never returns a token.
    a_fail_token: assert property (@(posedge clk) disable iff (!rst_n)
        done && (rsp.status != bra_pkg::ST_OK) |-> (rsp.new_token == '0))
        else $error("token returned on failure");

endmodule

bind bitmap_run_allocator bra_checker u_bra_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);

`default_nettype wire

// File: bench/testbench.sv
// Self-checking testbench of the bitmap run allocator.
// Depends on bra_pkg and bitmap_run_allocator; a local model predicts each result word.
`timescale 1ns / 1ps

module testbench;

    localparam int NUNITS    = bra_pkg::MAX_UNITS_DEF;
    localparam int UBYTES    = bra_pkg::UNIT_BYTES_DEF;
    localparam int TOK_W     = bra_pkg::TOK_W;
    localparam int SZ_W      = bra_pkg::SZ_W;
    localparam int FN_W      = bra_pkg::FN_W;
    localparam int CFG_IDX_W = bra_pkg::CFG_IDX_W;

    // Function code that the block does not know.
    localparam logic [FN_W-1:0] FUNC_BAD = 2'd3;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    bra_pkg::bra_req_t    req = '0;
    logic                 done;
    bra_pkg::bra_rsp_t    rsp;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = bra_pkg::CFG_TOTAL_UNITS;
    logic [SZ_W-1:0]      cfg_data = '0;

    bitmap_run_allocator i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    // Shadow copy of the allocator state and its registers.
    bit          occ_map [NUNITS];
    int unsigned hint_pos;
    int unsigned shadow_used;
    int unsigned unit_limit;
    int unsigned store_limit;

    bra_pkg::bra_req_t pending_words [$];
    bra_pkg::bra_rsp_t awaited_words [$];
    logic [TOK_W-1:0]  live_tokens [$];
    logic [SZ_W-1:0]   live_sizes [$];
    int          error_count = 0;
    bit          calm = 1'b0;

    function automatic int unsigned units_of(int unsigned bytes);
        return bytes / UBYTES + ((bytes % UBYTES) != 0 ? 1 : 0);
    endfunction

    // True when every unit of the run is occupied.
    function automatic bit run_occupied(int unsigned first, int unsigned cnt);
        for (int unsigned k = first; k < first + cnt; k++)
            if (!occ_map[k]) return 1'b0;
        return 1'b1;
    endfunction

    // Works out the result word of one request and updates the shadow state.
    function automatic bra_pkg::bra_rsp_t allocator_predict(bra_pkg::bra_req_t w);
        bra_pkg::bra_rsp_t r;
        int unsigned live, first, cnt, k, run;
        bit          addr_ok;
        live = (unit_limit < NUNITS) ? unit_limit : NUNITS;
        r.status = bra_pkg::ST_INVALID;
        r.new_token = '0;
        first = 32'(w.token) - 32'd1;
        cnt = units_of(32'(w.size_bytes));
        addr_ok = (w.token != 0) && (w.size_bytes != 0) && (first < live)
                  && (cnt <= live - first);
        if (w.func == bra_pkg::FUNC_ALLOC)
        begin
            if (w.size_bytes != 0 && 32'(w.size_bytes) <= store_limit)
            begin
                run = 0;
                for (k = hint_pos; k < live; k++)
                begin
                    run = occ_map[k] ? 0 : run + 1;
                    if (run == cnt) break;
                end
                if (hint_pos >= live || k >= live)
                begin
                    r.status = bra_pkg::ST_NOSPACE;
                end
                else
                begin
                    first = k + 1 - cnt;
                    for (k = first; k < first + cnt; k++) occ_map[k] = 1'b1;
                    shadow_used += cnt;
                    while (hint_pos < live && occ_map[hint_pos]) hint_pos++;
                    r.new_token = TOK_W'(first + 1);
                    r.status = bra_pkg::ST_OK;
                end
            end
        end
        else if (w.func == bra_pkg::FUNC_FREE)
        begin
            if (addr_ok && run_occupied(first, cnt))
            begin
                for (k = first; k < first + cnt; k++) occ_map[k] = 1'b0;
                shadow_used -= cnt;
                if (first < hint_pos) hint_pos = first;
                r.status = bra_pkg::ST_OK;
            end
        end
        else if (w.func == bra_pkg::FUNC_CHECK)
        begin
            if (32'(w.size_bytes) <= store_limit && addr_ok && run_occupied(first, cnt))
                r.status = bra_pkg::ST_OK;
        end
        r.used_count = shadow_used[TOK_W-1:0];
        return r;
    endfunction

    // Driver: issues pending words, idling at random unless calm.
    always @(posedge clk)
    begin
        bra_pkg::bra_rsp_t exp_w;
        if (start && !busy)
        begin
            exp_w = allocator_predict(req);
            awaited_words.push_back(exp_w);
            if (req.func == bra_pkg::FUNC_ALLOC && exp_w.status == bra_pkg::ST_OK)
            begin
                live_tokens.push_back(exp_w.new_token);
                live_sizes.push_back(req.size_bytes);
            end
        end
        if (!start || !busy)
        begin
            if (pending_words.size() != 0 && (calm || $urandom_range(0, 99) >= 28))
            begin
                req <= pending_words.pop_front();
                start <= 1'b1;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: compares each result word with the oldest expectation.
    always @(posedge clk)
    begin
        bra_pkg::bra_rsp_t exp_w;
        if (done)
        begin
            if (awaited_words.size() == 0)
            begin
                $error("unexpected result word: status %0d", rsp.status);
                error_count++;
            end
            else
            begin
                exp_w = awaited_words.pop_front();
                if (rsp.status !== exp_w.status)
                begin
                    $error("status: expected %0d, got %0d", exp_w.status, rsp.status);
                    error_count++;
                end
                if (rsp.new_token !== exp_w.new_token)
                begin
                    $error("new_token: expected %0d, got %0d", exp_w.new_token, rsp.new_token);
                    error_count++;
                end
                if (rsp.used_count !== exp_w.used_count)
                begin
                    $error("used_count: expected %0d, got %0d",
                           exp_w.used_count, rsp.used_count);
                    error_count++;
                end
            end
        end
    end

    task automatic push_word(logic [FN_W-1:0] f, logic [TOK_W-1:0] t, logic [SZ_W-1:0] s);
        bra_pkg::bra_req_t w;
        w.func = f;
        w.token = t;
        w.size_bytes = s;
        pending_words.push_back(w);
    endtask

    task automatic wait_idle();
        do
        begin
            @(posedge clk);
            #1;
        end while (pending_words.size() != 0 || start || awaited_words.size() != 0 || busy);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SZ_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        if (idx == bra_pkg::CFG_TOTAL_UNITS) unit_limit = 32'(val[TOK_W-1:0]);
        else store_limit = 32'(val);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random requests: allocations, frees and checks of live runs, with some noise.
    task automatic random_words(int n, int tok_hi);
        int unsigned sel, pick;
        logic [SZ_W-1:0] sz;
        for (int j = 0; j < n; j++)
        begin
            while (pending_words.size() >= 4) @(posedge clk);
            sel = $urandom_range(0, 99);
            case ($urandom_range(0, 9))
                0:       sz = SZ_W'($urandom());
                1:       sz = SZ_W'($urandom_range(1, 4) * UBYTES);
                default: sz = SZ_W'($urandom_range(1, 8 * UBYTES));
            endcase
            if (sel < 45)
            begin
                push_word(bra_pkg::FUNC_ALLOC, TOK_W'($urandom()), sz);
            end
            else if (sel < 95 && live_tokens.size() != 0)
            begin
                pick = $urandom_range(0, live_tokens.size() - 1);
                if ($urandom_range(0, 99) < 85) sz = live_sizes[pick];
                if (sel < 80)
                begin
                    push_word(bra_pkg::FUNC_FREE, live_tokens[pick], sz);
                    live_tokens.delete(pick);
                    live_sizes.delete(pick);
                end
                else
                begin
                    push_word(bra_pkg::FUNC_CHECK, live_tokens[pick], sz);
                end
            end
            else
            begin
                push_word(FN_W'($urandom()), ($urandom_range(0, 9) == 0) ? TOK_W'($urandom())
                          : TOK_W'($urandom_range(0, tok_hi)), sz);
            end
        end
    endtask

    // Stimulus phases, with register changes only while the block is idle.
    initial
    begin
        for (int k = 0; k < NUNITS; k++) occ_map[k] = 1'b0;
        hint_pos = 0;
        shadow_used = 0;
        unit_limit = 32'(bra_pkg::TOTAL_UNITS_RST);
        store_limit = 32'(bra_pkg::STORE_BYTES_RST);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        wait_idle();

        // Directed words: extremes and special cases.
        push_word(bra_pkg::FUNC_ALLOC, 13'd0, 25'd16777216);
        push_word(bra_pkg::FUNC_CHECK, 13'd1, 25'd16777216);
        push_word(bra_pkg::FUNC_FREE, 13'd1, 25'd16777216);
        push_word(bra_pkg::FUNC_ALLOC, 13'd0, 25'd0);
        push_word(bra_pkg::FUNC_ALLOC, 13'd8191, 25'd1);
        push_word(bra_pkg::FUNC_ALLOC, 13'd0, 25'd4096);
        push_word(bra_pkg::FUNC_ALLOC, 13'd0, 25'd4097);
        push_word(bra_pkg::FUNC_ALLOC, 13'd0, 25'd16777217);
        push_word(bra_pkg::FUNC_ALLOC, 13'd0, 25'h1FFFFFF);
        push_word(bra_pkg::FUNC_ALLOC, 13'd0, 25'd16777216);
        push_word(FUNC_BAD, 13'd1, 25'd1);
        push_word(bra_pkg::FUNC_FREE, 13'd0, 25'd1);
        push_word(bra_pkg::FUNC_FREE, 13'd1, 25'd0);
        push_word(bra_pkg::FUNC_FREE, 13'd8191, 25'd1);
        push_word(bra_pkg::FUNC_FREE, 13'd4096, 25'd8192);
        push_word(bra_pkg::FUNC_FREE, 13'd10, 25'd1);
        push_word(bra_pkg::FUNC_CHECK, 13'd2, 25'd8192);
        push_word(bra_pkg::FUNC_CHECK, 13'd0, 25'd1);
        push_word(bra_pkg::FUNC_CHECK, 13'd2, 25'd16777217);
        push_word(bra_pkg::FUNC_CHECK, 13'd2, 25'd16384);
        push_word(bra_pkg::FUNC_FREE, 13'd1, 25'd4096);
        push_word(bra_pkg::FUNC_ALLOC, 13'd0, 25'd1);
        push_word(bra_pkg::FUNC_FREE, 13'd4, 25'd4096);
        wait_idle();

        calm = 1'b1;
        random_words(60, 64);
        calm = 1'b0;
        random_words(100, 64);
        wait_idle();

        // Small map below the occupied units, small store.
        write_reg(bra_pkg::CFG_TOTAL_UNITS, 25'd64);
        write_reg(bra_pkg::CFG_STORE_BYTES, 25'd65536);
        random_words(100, 80);
        wait_idle();

        // Both registers at zero.
        write_reg(bra_pkg::CFG_TOTAL_UNITS, 25'd0);
        write_reg(bra_pkg::CFG_STORE_BYTES, 25'd0);
        random_words(12, 8);
        wait_idle();

        // Both registers at their widest values.
        write_reg(bra_pkg::CFG_TOTAL_UNITS, 25'h1FFF);
        write_reg(bra_pkg::CFG_STORE_BYTES, 25'h1FFFFFF);
        random_words(100, 4200);
        wait_idle();

        write_reg(bra_pkg::CFG_TOTAL_UNITS, 25'd4096);
        write_reg(bra_pkg::CFG_STORE_BYTES, 25'd16777216);
        random_words(80, 200);
        wait_idle();
        repeat (100) @(posedge clk);

        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #200ms;
        $display("testbench: done, errors");
        $finish;
    end

endmodule

// File: files.f
src/bra_pkg.sv
src/bra_ctrl.sv
src/bra_dp.sv
src/bitmap_run_allocator.sv
src/bra_checker.sv
bench/testbench.sv
